// ----- rtl/sfd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the stuffed frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

    // Largest frame length honored; longer lengths are clamped to it
    localparam int unsigned MAX_FRAME = 4095;

    // Frame layout
    localparam logic [11:0] POS_OPC_HI   = 12'd1;
    localparam logic [11:0] POS_OPC_LO   = 12'd2;
    localparam logic [11:0] POS_BLK_HI   = 12'd3;
    localparam logic [11:0] POS_BLK_LO   = 12'd4;
    localparam logic [11:0] POS_PAYLOAD  = 12'd5;
    localparam logic [11:0] FRAME_OVHD   = 12'd6;
    localparam logic [11:0] MIN_LEN      = 12'd5;
    localparam logic [7:0]  CODE_MAX     = 8'hFF;

    // Result queue geometry
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_SHORT     = 2'd2
    } t_status;

    typedef enum logic {
        KIND_DATA    = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    // Stuffing decoder phase
    typedef enum logic [3:0] {
        PH_CODE  = 4'b0001,
        PH_AFTER = 4'b0010,
        PH_COPY  = 4'b0100,
        PH_IDLE  = 4'b1000
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [15:0] opcode;
        logic [15:0] block_number;
        logic [11:0] decoded_length;
        t_status     status;
        logic        last;
    } t_result;

    // Results produced by one request: cnt of 0, 1 or 2, in res0 then res1
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

// ----- rtl/sfd_step.sv -----
// ----------------------------------------------------------------------------
// sfd_step
// Per-byte frame tracking and stuffing decode; yields up to two results
// for every accepted request.
// ----------------------------------------------------------------------------
module sfd_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_data,
    input  logic          i_accept,
    input  logic [7:0]    i_frame_byte,
    input  logic [11:0]   i_frame_length,
    output sfd_pkg::t_push o_push
);
    import sfd_pkg::*;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] code;
        logic       err;
    } t_take;

    logic [7:0]  r_flag;
    logic [11:0] r_pos,   n_pos;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_code,  n_code;
    logic [7:0]  r_rem,   n_rem;
    logic [15:0] r_opc,   n_opc;
    logic [15:0] r_blk,   n_blk;
    logic [11:0] r_count, n_count;
    logic        r_err,   n_err;

    logic [11:0] len_c;
    logic        is_last;
    logic [11:0] idx;
    logic [11:0] n_reg;
    logic        at_end;
    t_take       tk;
    t_push       push;

    // Code byte handling: reduce above flag, check for overrun
    function automatic t_take take_code(input logic [7:0]  x,
                                        input logic [11:0] ix,
                                        input logic [11:0] nn,
                                        input logic [7:0]  flag,
                                        input logic [7:0]  cur);
        t_take       t;
        logic [7:0]  c;
        c       = (x > flag) ? x - 8'd1 : x;
        t.phase = PH_AFTER;
        t.code  = c;
        t.err   = 1'b0;
        if (({1'b0, ix} + 13'd1) >= {1'b0, nn}) begin
            t.phase = PH_IDLE;
            t.code  = cur;
        end else if ((({1'b0, ix} + {5'b0, c}) > {1'b0, nn}) && (c != 8'd1)) begin
            t.phase = PH_IDLE;
            t.code  = cur;
            t.err   = 1'b1;
        end
        return t;
    endfunction

    function automatic t_result data_res(input logic [7:0] b);
        t_result r;
        r           = '0;
        r.kind      = KIND_DATA;
        r.data_byte = b;
        return r;
    endfunction

    // Length clamp and frame geometry
    always_comb begin
        len_c   = ({5'b0, i_frame_length} > 17'(MAX_FRAME)) ? 12'(MAX_FRAME)
                                                             : i_frame_length;
        is_last = ({1'b0, r_pos} + 13'd1) >= {1'b0, len_c};
        idx     = r_pos - POS_PAYLOAD;
        n_reg   = len_c - FRAME_OVHD;
        at_end  = ({1'b0, idx} + 13'd1) >= {1'b0, n_reg};
    end

    // Next state and results for the current request
    always_comb begin
        n_pos   = r_pos;
        n_phase = r_phase;
        n_code  = r_code;
        n_rem   = r_rem;
        n_opc   = r_opc;
        n_blk   = r_blk;
        n_count = r_count;
        n_err   = r_err;
        push    = '0;
        tk      = take_code(i_frame_byte, idx, n_reg, r_flag, r_code);

        if (i_accept) begin
            n_pos = r_pos + 12'd1;

            // header capture
            unique case (r_pos)
                POS_OPC_HI: n_opc = {i_frame_byte, r_opc[7:0]};
                POS_OPC_LO: n_opc = {r_opc[15:8], i_frame_byte};
                POS_BLK_HI: n_blk = {i_frame_byte, r_blk[7:0]};
                POS_BLK_LO: n_blk = {r_blk[15:8], i_frame_byte};
                default: ;
            endcase

            if (is_last) begin
                // summary closes the frame
                push.cnt              = 2'd1;
                push.res0             = '0;
                push.res0.kind        = KIND_SUMMARY;
                push.res0.last        = 1'b1;
                if (len_c < MIN_LEN) begin
                    push.res0.status = ST_SHORT;
                end else begin
                    push.res0.opcode       = n_opc;
                    push.res0.block_number = n_blk;
                    if (r_err) begin
                        push.res0.status = ST_MALFORMED;
                    end else begin
                        push.res0.status         = ST_OK;
                        push.res0.decoded_length = r_count;
                    end
                end
                n_pos   = '0;
                n_phase = PH_CODE;
                n_code  = '0;
                n_rem   = '0;
                n_opc   = '0;
                n_blk   = '0;
                n_count = '0;
                n_err   = 1'b0;
            end else if ((r_pos >= POS_PAYLOAD) && (len_c > FRAME_OVHD)) begin
                unique case (r_phase)
                    PH_CODE: begin
                        n_phase = tk.phase;
                        n_code  = tk.code;
                        n_err   = r_err | tk.err;
                    end
                    PH_AFTER: begin
                        if (i_frame_byte == r_flag) begin
                            n_phase = tk.phase;
                            n_code  = tk.code;
                            n_err   = r_err | tk.err;
                        end else if (r_code <= 8'd1) begin
                            push.cnt  = 2'd1;
                            push.res0 = data_res(r_flag);
                            n_phase   = tk.phase;
                            n_code    = tk.code;
                            n_err     = r_err | tk.err;
                        end else begin
                            push.cnt  = 2'd1;
                            push.res0 = data_res(i_frame_byte);
                            n_rem     = r_code - 8'd2;
                            if (n_rem == 8'd0) begin
                                n_phase = PH_CODE;
                                if ((r_code != CODE_MAX) && !at_end) begin
                                    push.cnt  = 2'd2;
                                    push.res1 = data_res(r_flag);
                                end
                            end else begin
                                n_phase = PH_COPY;
                            end
                        end
                    end
                    PH_COPY: begin
                        push.cnt  = 2'd1;
                        push.res0 = data_res(i_frame_byte);
                        n_rem     = r_rem - 8'd1;
                        if (n_rem == 8'd0) begin
                            n_phase = PH_CODE;
                            if ((r_code != CODE_MAX) && !at_end) begin
                                push.cnt  = 2'd2;
                                push.res1 = data_res(r_flag);
                            end
                        end
                    end
                    PH_IDLE: ;
                    default: ;
                endcase
                n_count = r_count + 12'(push.cnt);
            end
        end
    end

    assign o_push = push;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= '0;
        end else if (i_cfg_we) begin
            r_flag <= i_cfg_data;
        end
    end

    // Frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= PH_CODE;
            r_code  <= '0;
            r_rem   <= '0;
            r_opc   <= '0;
            r_blk   <= '0;
            r_count <= '0;
            r_err   <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_code  <= n_code;
            r_rem   <= n_rem;
            r_opc   <= n_opc;
            r_blk   <= n_blk;
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

    // An overrun always parks the decoder until the frame ends
    a_err_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> (r_phase == PH_IDLE))
        else $error("error flag set outside idle phase");

    // State only moves on an accepted request
    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_pos) && $stable(r_count))
        else $error("frame state moved without a request");

    // A summary travels alone
    a_summary_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.cnt != 2'd0 && push.res0.kind == KIND_SUMMARY) |-> (push.cnt == 2'd1))
        else $error("summary pushed together with data");

endmodule

// ----- rtl/sfd_res_queue.sv -----
// ----------------------------------------------------------------------------
// sfd_res_queue
// Small result queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module sfd_res_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sfd_pkg::t_push   i_push,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_space2,
    output sfd_pkg::t_result o_res
);
    import sfd_pkg::*;

    t_result             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr, n_wr;
    logic [QPTR_W-1:0]   r_rd, n_rd;
    logic [QCNT_W-1:0]   r_count, n_count;
    logic                pop;
    logic [QPTR_W-1:0]   wr1;

    assign pop      = i_pop && (r_count != '0);
    assign wr1      = r_wr + QPTR_W'(1);
    assign o_valid  = (r_count != '0);
    assign o_space2 = (r_count <= QCNT_W'(QUEUE_DEPTH - 2));
    assign o_res    = r_mem[r_rd];

    // Pointer and occupancy update
    always_comb begin
        n_wr    = r_wr + QPTR_W'(i_push.cnt);
        n_rd    = r_rd + QPTR_W'(pop);
        n_count = r_count + QCNT_W'(i_push.cnt) - QCNT_W'(pop);
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> o_space2)
        else $error("push into a queue without room for two");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr - r_rd) == QPTR_W'(r_count))
        else $error("queue pointers disagree with occupancy");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_res.kind == KIND_SUMMARY) == o_res.last))
        else $error("summary kind and last flag disagree");

endmodule

// ----- rtl/stuffed_frame_decoder_top.sv -----
// ----------------------------------------------------------------------------
// stuffed_frame_decoder_top
// Byte-wise frame decoder with COBS-style unstuffing and a frame summary.
// ----------------------------------------------------------------------------
// One frame byte is taken per request and a new request can be accepted every
// cycle; each byte is fully processed in the cycle it is accepted and its
// results (none, one or two decoded bytes, or one summary) go into a 4-entry
// result queue that hands out one result per cycle. Request ready is high
// while the queue holds two results or fewer, so the input stalls only when
// the output side is held off or when bursts of two-result bytes (a last
// copied byte followed by a restored flag byte) outpace the single output
// port. Decoded bytes flow out as they are known; a malformed frame is
// reported only in its summary, and the bytes already delivered for it must
// be dropped downstream. The user must write flag_value through i_cfg_we/
// i_cfg_data only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module stuffed_frame_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic [11:0] i_frame_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_opcode,
    output logic [15:0] o_block_number,
    output logic [11:0] o_decoded_length,
    output logic [1:0]  o_status,
    output logic        o_last
);
    import sfd_pkg::*;

    logic    accept;
    logic    space2;
    t_push   push;
    t_result res;

    assign o_ready = space2;
    assign accept  = i_valid && space2;

    // Frame tracking and unstuffing
    sfd_step u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_frame_byte   (i_frame_byte),
        .i_frame_length (i_frame_length),
        .o_push         (push)
    );

    // Result buffering toward the consumer
    sfd_res_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (i_ready),
        .o_valid  (o_valid),
        .o_space2 (space2),
        .o_res    (res)
    );

    assign o_kind           = res.kind;
    assign o_data_byte      = res.data_byte;
    assign o_opcode         = res.opcode;
    assign o_block_number   = res.block_number;
    assign o_decoded_length = res.decoded_length;
    assign o_status         = res.status;
    assign o_last           = res.last;

    a_push_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |-> (push.cnt == 2'd0))
        else $error("results produced without an accepted request");

    a_ready_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !accept && o_ready) |=> o_ready)
        else $error("ready low after a drain with no new request");

    a_data_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_DATA) |-> (o_status == ST_OK && !o_last))
        else $error("data result carries summary fields");

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stuffed_frame_decoder_top. A scoreboard predicts the
// decoded bytes and frame summaries for every accepted request; directed and
// random frames (well-formed stuffing, corrupted, short, length changes) run
// under several flag settings with random stalls and a long result hold-off.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfd_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYC   = 9;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYC    = 100;
    localparam int PHASE_REQS  = 12;
    localparam int SETTLE_CYC  = 3;

    // Predicts decoder results and matches them against what comes out
    class unstuff_scoreboard;
        logic [7:0]  flag_value;
        int          byte_pos;
        t_phase      phase;
        logic [7:0]  code;
        logic [7:0]  copy_left;
        logic [15:0] opcode_acc;
        logic [15:0] block_acc;
        logic [11:0] out_count;
        bit          overrun;
        t_result     expected_results[$];
        int          failures;
        int          data_checked;
        int          ok_frames;
        int          malformed_frames;
        int          short_frames;

        function new();
            flag_value = 8'h00;
            failures = 0;
            data_checked = 0;
            ok_frames = 0;
            malformed_frames = 0;
            short_frames = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_pos = 0;
            phase = PH_CODE;
            code = 8'h00;
            copy_left = 8'h00;
            opcode_acc = 16'h0000;
            block_acc = 16'h0000;
            out_count = 12'h000;
            overrun = 1'b0;
        endfunction

        function void emit_decoded(logic [7:0] b);
            t_result r;
            r = '0;
            r.kind = KIND_DATA;
            r.data_byte = b;
            r.status = ST_OK;
            expected_results.push_back(r);
            out_count = out_count + 12'd1;
        endfunction

        function void take_code_byte(logic [7:0] b, int idx, int n);
            int c;
            c = b;
            if (idx + 1 >= n) begin
                phase = PH_IDLE;
                return;
            end
            if (c > flag_value) c--;
            // code runs past the end of the stuffed region
            if (idx + c > n && c != 1) begin
                overrun = 1'b1;
                phase = PH_IDLE;
                return;
            end
            code = 8'(c);
            phase = PH_AFTER;
        endfunction

        function void close_copy_run(int idx, int n);
            if (code != CODE_MAX && idx + 1 < n) emit_decoded(flag_value);
            phase = PH_CODE;
        endfunction

        function void decode_payload_byte(logic [7:0] b, int idx, int n);
            case (phase)
                PH_CODE: take_code_byte(b, idx, n);
                PH_AFTER: begin
                    if (b == flag_value) begin
                        take_code_byte(b, idx, n);
                    end else if (code <= 8'd1) begin
                        emit_decoded(flag_value);
                        take_code_byte(b, idx, n);
                    end else begin
                        emit_decoded(b);
                        copy_left = code - 8'd2;
                        if (copy_left == 8'd0) close_copy_run(idx, n);
                        else phase = PH_COPY;
                    end
                end
                PH_COPY: begin
                    emit_decoded(b);
                    copy_left = copy_left - 8'd1;
                    if (copy_left == 8'd0) close_copy_run(idx, n);
                end
                default: ;
            endcase
        endfunction

        // One accepted request: frame byte plus the length sent with it
        function void note_request(logic [7:0] b, logic [11:0] len);
            int      total;
            int      pos;
            t_result r;
            total = len;
            if (total > MAX_FRAME) total = MAX_FRAME;
            pos = byte_pos;
            if (pos == POS_OPC_HI) opcode_acc[15:8] = b;
            else if (pos == POS_OPC_LO) opcode_acc[7:0] = b;
            else if (pos == POS_BLK_HI) block_acc[15:8] = b;
            else if (pos == POS_BLK_LO) block_acc[7:0] = b;

            if (pos + 1 >= total) begin
                r = '0;
                r.kind = KIND_SUMMARY;
                r.last = 1'b1;
                if (total < MIN_LEN) begin
                    r.status = ST_SHORT;
                end else begin
                    r.opcode = opcode_acc;
                    r.block_number = block_acc;
                    r.status = overrun ? ST_MALFORMED : ST_OK;
                    r.decoded_length = overrun ? 12'd0 : out_count;
                end
                expected_results.push_back(r);
                clear_frame();
                return;
            end
            if (pos >= POS_PAYLOAD && total > FRAME_OVHD)
                decode_payload_byte(b, pos - POS_PAYLOAD, total - FRAME_OVHD);
            byte_pos = pos + 1;
        endfunction

        function void check_result(t_result got);
            t_result want;
            bit      bad;
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected: k=%0d d=%02h op=%04h blk=%04h len=%0d st=%0d l=%0d",
                             got.kind, got.data_byte, got.opcode, got.block_number,
                             got.decoded_length, got.status, got.last);
                return;
            end
            want = expected_results.pop_front();
            bad = (got.kind !== want.kind) || (got.data_byte !== want.data_byte) ||
                  (got.opcode !== want.opcode) || (got.block_number !== want.block_number) ||
                  (got.decoded_length !== want.decoded_length) ||
                  (got.status !== want.status) || (got.last !== want.last);
            if (bad) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch exp: k=%0d d=%02h op=%04h blk=%04h len=%0d st=%0d l=%0d",
                             want.kind, want.data_byte, want.opcode, want.block_number,
                             want.decoded_length, want.status, want.last);
                    $display("         got: k=%0d d=%02h op=%04h blk=%04h len=%0d st=%0d l=%0d",
                             got.kind, got.data_byte, got.opcode, got.block_number,
                             got.decoded_length, got.status, got.last);
                end
            end else if (want.kind == KIND_DATA) begin
                data_checked++;
            end else begin
                case (want.status)
                    ST_OK:        ok_frames++;
                    ST_MALFORMED: malformed_frames++;
                    default:      short_frames++;
                endcase
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_data = 8'h00;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_frame_byte = 8'h00;
    logic [11:0] i_frame_length = 12'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_kind;
    logic [7:0]  o_data_byte;
    logic [15:0] o_opcode;
    logic [15:0] o_block_number;
    logic [11:0] o_decoded_length;
    logic [1:0]  o_status;
    logic        o_last;

    unstuff_scoreboard sb = new();

    logic [7:0] frame_bytes[$];
    logic [7:0] flag_cfg = 8'h00;
    bit         idle_on = 1'b1;
    bit         hold_rx = 1'b0;
    int         requests_sent = 0;
    int         idle_cycles = 0;
    int         flag_settings = 1;

    stuffed_frame_decoder_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_frame_byte     (i_frame_byte),
        .i_frame_length   (i_frame_length),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kind           (o_kind),
        .o_data_byte      (o_data_byte),
        .o_opcode         (o_opcode),
        .o_block_number   (o_block_number),
        .o_decoded_length (o_decoded_length),
        .o_status         (o_status),
        .o_last           (o_last)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Sample both handshakes; pre-edge values are seen here
    always @(posedge i_clk) begin : monitor
        t_result seen;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                sb.note_request(i_frame_byte, i_frame_length);
                moved = 1'b1;
            end
            if (o_valid && i_ready) begin
                seen.kind = t_kind'(o_kind);
                seen.data_byte = o_data_byte;
                seen.opcode = o_opcode;
                seen.block_number = o_block_number;
                seen.decoded_length = o_decoded_length;
                seen.status = t_status'(o_status);
                seen.last = o_last;
                sb.check_result(seen);
                moved = 1'b1;
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    // Watchdog: too long without any handshake
    initial begin
        do @(negedge i_clk); while (idle_cycles < STALL_LIMIT);
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("** stuffed_frame_decoder_top: FAILED **");
        $finish;
    end

    // Result side: random stall per result, long hold-off on request
    initial begin : receiver
        int wait_cyc;
        @(posedge i_clk);
        forever begin
            wait_cyc = idle_on ? $urandom_range(0, 3) : 0;
            if (hold_rx) begin
                wait_cyc = HOLD_CYC;
                hold_rx = 1'b0;
            end
            if (wait_cyc > 0) begin
                i_ready <= 1'b0;
                repeat (wait_cyc) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    // Offer one request and hold it until taken; leaves valid high
    task automatic send_byte(input logic [7:0] b, input logic [11:0] len);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_frame_byte <= b;
        i_frame_length <= len;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        requests_sent++;
    endtask

    task automatic send_frame(input logic [11:0] len);
        foreach (frame_bytes[k]) send_byte(frame_bytes[k], len);
    endtask

    // Wait past the monitor so the last accepted request is already predicted
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.expected_results.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic set_flag(input logic [7:0] v);
        wait_results_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.flag_value = v;
        flag_cfg = v;
        flag_settings++;
    endtask

    task automatic fill_random(input int count);
        frame_bytes.delete();
        repeat (count) frame_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Frame with a stuffed payload laid out to fit the given total length
    task automatic build_stuffed_frame(input int total, input bit corrupt, input bit long_first);
        int         n;
        int         idx;
        int         c;
        int         r;
        int         room;
        int         k;
        logic [7:0] raw;
        frame_bytes.delete();
        frame_bytes.push_back(flag_cfg);
        repeat (4) frame_bytes.push_back(8'($urandom_range(0, 255)));
        n = total - 6;
        idx = 0;
        while (idx < n) begin
            room = (n - idx > 255) ? 255 : n - idx;
            r = $urandom_range(0, 9);
            if (long_first && idx == 0) c = room;
            else if (r < 2) c = 1;
            else if (r == 2) c = room;
            else c = $urandom_range(1, (room < 8) ? room : 8);
            if (c == 255 && flag_cfg != 8'hFF) c = 254;
            // raw code that reduces to the wanted run length
            if (r == 3 && !(long_first && idx == 0)) begin
                raw = 8'h00;
                c = 1;
            end else if (c < flag_cfg || c == 255) begin
                raw = 8'(c);
            end else begin
                raw = 8'(c + 1);
            end
            frame_bytes.push_back(raw);
            for (k = 1; k < c; k++)
                frame_bytes.push_back((k == 1 && $urandom_range(0, 9) == 0) ?
                                      flag_cfg : 8'($urandom_range(0, 255)));
            idx += c;
        end
        frame_bytes.push_back(flag_cfg);
        if (corrupt)
            frame_bytes[$urandom_range(1, frame_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    endtask

    // Random mix of frame types until the request budget is used
    task automatic run_phase(input int budget);
        int start;
        int pick;
        int len;
        int big;
        int k;
        int j;
        start = requests_sent;
        while (requests_sent - start < budget) begin
            idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                len = ($urandom_range(0, 29) == 0) ? $urandom_range(200, 300) :
                                                     $urandom_range(7, 40);
                build_stuffed_frame(len, pick >= 60, 1'b0);
                send_frame(12'(len));
            end else if (pick < 93) begin
                // noise frames, short ones included
                len = (pick < 84) ? $urandom_range(0, 40) : $urandom_range(0, 6);
                fill_random((len == 0) ? 1 : len);
                send_frame(12'(len));
            end else begin
                // length changes mid-frame and closes the frame early
                big = $urandom_range(16, 4095);
                k = $urandom_range(1, 10);
                fill_random(k + 1);
                for (j = 0; j < k; j++) send_byte(frame_bytes[j], 12'(big));
                send_byte(frame_bytes[k], 12'($urandom_range(0, k)));
            end
            if (pick % 17 == 0) wait_results_drained();
        end
    endtask

    // Main sequence
    initial begin
        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: length 0, too short, header extremes, lone code byte,
        // overrunning code, length change that closes the frame
        idle_on = 1'b0;
        frame_bytes = '{8'hA5};
        send_frame(12'd0);
        frame_bytes = '{8'h00, 8'hFF, 8'hFF, 8'hFF};
        send_frame(12'd4);
        frame_bytes = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h03, 8'h00};
        send_frame(12'd7);
        frame_bytes = '{8'h00, 8'h12, 8'h34, 8'h56, 8'h78, 8'h05, 8'h11, 8'h00};
        send_frame(12'd8);
        send_byte(8'h00, 12'd4095);
        send_byte(8'h01, 12'd4095);
        send_byte(8'h02, 12'd4095);
        send_byte(8'h80, 12'd1);

        run_phase(PHASE_REQS);

        // all-ones flag, with a long receiver hold-off during a long frame
        set_flag(8'hFF);
        idle_on = 1'b0;
        hold_rx = 1'b1;
        build_stuffed_frame(262, 1'b0, 1'b1);
        send_frame(12'd262);
        wait_results_drained();
        run_phase(PHASE_REQS);

        set_flag(8'h7E);
        run_phase(PHASE_REQS);
        set_flag(8'($urandom_range(2, 253)));
        run_phase(PHASE_REQS);
        set_flag(8'h01);
        run_phase(PHASE_REQS);
        set_flag(8'h00);
        run_phase(PHASE_REQS);

        wait_results_drained();
        repeat (10) @(posedge i_clk);

        $display("Ran %0d requests under %0d flag settings; %0d decoded bytes matched.",
                 requests_sent, flag_settings, sb.data_checked);
        $display("Frame summaries matched: %0d ok, %0d malformed, %0d too short; %0d failures.",
                 sb.ok_frames, sb.malformed_frames, sb.short_frames, sb.failures);
        if (sb.failures == 0 && sb.expected_results.size() == 0)
            $display("** stuffed_frame_decoder_top: PASSED **");
        else
            $display("** stuffed_frame_decoder_top: FAILED **");
        $finish;
    end

endmodule
